// File: rtl/core/sfre_pkg.sv
// Shared types and constants for the SPI flash range erase sequencer.
// Holds flash opcodes, default geometry and the transfer record types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sfre_pkg;

   // Default flash geometry
   localparam int SECTOR_COUNT_DEF  = 512;
   localparam int SECTOR_BYTES_DEF  = 4096;
   localparam int BLOCK_SECTORS_DEF = 8;

   // Field widths
   localparam int SEC_W  = 10;
   localparam int ADDR_W = 21;
   localparam int BYTE_W = 8;

   // Flash command bytes
   localparam logic [BYTE_W-1:0] OP_RDSR = 8'h05;  // read status
   localparam logic [BYTE_W-1:0] OP_EWSR = 8'h50;  // enable status write
   localparam logic [BYTE_W-1:0] OP_WRSR = 8'h01;  // write status
   localparam logic [BYTE_W-1:0] OP_WREN = 8'h06;  // write enable
   localparam logic [BYTE_W-1:0] OP_SE   = 8'h20;  // sector erase
   localparam logic [BYTE_W-1:0] OP_CE   = 8'h60;  // chip erase
   localparam logic [BYTE_W-1:0] OP_BE32 = 8'h52;  // 32KB block erase
   localparam logic [BYTE_W-1:0] OP_NONE = 8'h00;  // no command carried

   // Status value that means the erase is still running
   localparam logic [BYTE_W-1:0] STATUS_BUSY = 8'h03;

   // Request actions
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_DONE  = 1'b1;

   typedef struct packed {
      logic              action;
      logic [SEC_W-1:0]  first_sector;
      logic [SEC_W-1:0]  last_sector;
      logic [BYTE_W-1:0] returned_byte;
   } req_item_type;

   typedef struct packed {
      logic              valid;
      req_item_type      item;
   } req_slot_type;

   typedef struct packed {
      logic [BYTE_W-1:0] opcode;
      logic              send_address;
      logic [ADDR_W-1:0] address;
      logic              send_data;
      logic [BYTE_W-1:0] data_byte;
      logic              read_reply;
      logic              finished;
      logic              failed;
   } rsp_item_type;

   typedef struct packed {
      logic              has_rsp;
      rsp_item_type      item;
   } step_out_type;

endpackage

`default_nettype wire

// File: rtl/core/spi_flash_range_erase_sequencer_top.sv
// SPI flash range erase sequencer, top level.
// Channels: req_* carries one event per transfer: a start (action 0) with two
// sector numbers in either order, or a completion (action 1) of the command
// last issued, with the status byte it read back. rsp_* carries the next flash
// command (opcode, optional address, optional data byte, read flag) or an end
// marker (finished, with failed set for a sector beyond the flash).
// Flow: a request taken into the input register passes through the core into the
// output register, which drives rsp_valid.
// Throughput: one request per cycle unless the result stalls; the phase machine
// and counters advance in one register-to-register step, with one address multiply.
// Starts while a sequence runs and completions while idle give no result.
// Reset: synchronous, clears the phase machine, counters and both valid flags.
// Stall: a stalled result holds; one more request may still be taken into the
// input register, after which req_stall rises until the result drains.
// Depends on sfre_pkg, sfre_in_stage, sfre_core and sfre_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module spi_flash_range_erase_sequencer_top #(
   parameter int SECTOR_COUNT  = sfre_pkg::SECTOR_COUNT_DEF,
   parameter int SECTOR_BYTES  = sfre_pkg::SECTOR_BYTES_DEF,
   parameter int BLOCK_SECTORS = sfre_pkg::BLOCK_SECTORS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_action,
   input  wire logic [sfre_pkg::SEC_W-1:0]    req_first_sector,
   input  wire logic [sfre_pkg::SEC_W-1:0]    req_last_sector,
   input  wire logic [sfre_pkg::BYTE_W-1:0]   req_returned_byte,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [sfre_pkg::BYTE_W-1:0]   rsp_opcode,
   output      logic                          rsp_send_address,
   output      logic [sfre_pkg::ADDR_W-1:0]   rsp_address,
   output      logic                          rsp_send_data,
   output      logic [sfre_pkg::BYTE_W-1:0]   rsp_data_byte,
   output      logic                          rsp_read_reply,
   output      logic                          rsp_finished,
   output      logic                          rsp_failed
);

   sfre_pkg::req_item_type req_item;
   sfre_pkg::req_slot_type slot;
   sfre_pkg::step_out_type step;
   sfre_pkg::rsp_item_type rsp_item;
   logic                   out_free;
   logic                   take;

   assign req_item.action        = req_action;
   assign req_item.first_sector  = req_first_sector;
   assign req_item.last_sector   = req_last_sector;
   assign req_item.returned_byte = req_returned_byte;

   // Request moves through the core when the result register has room
   assign take = slot.valid && out_free;

   sfre_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_item  (req_item),
      .take     (take),
      .slot     (slot)
   );

   sfre_core #(
      .SECTOR_COUNT  (SECTOR_COUNT),
      .SECTOR_BYTES  (SECTOR_BYTES),
      .BLOCK_SECTORS (BLOCK_SECTORS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (slot.item),
      .step  (step)
   );

   sfre_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .step      (step),
      .out_free  (out_free),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_item)
   );

   assign rsp_opcode       = rsp_item.opcode;
   assign rsp_send_address = rsp_item.send_address;
   assign rsp_address      = rsp_item.address;
   assign rsp_send_data    = rsp_item.send_data;
   assign rsp_data_byte    = rsp_item.data_byte;
   assign rsp_read_reply   = rsp_item.read_reply;
   assign rsp_finished     = rsp_item.finished;
   assign rsp_failed       = rsp_item.failed;

endmodule

`default_nettype wire

// File: rtl/core/sfre_in_stage.sv
// Input register of the erase sequencer: holds one request transfer.
// Depends on sfre_pkg for the request record.
`timescale 1ns / 1ps
`default_nettype none

module sfre_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_stall,
   input  wire sfre_pkg::req_item_type in_item,
   input  wire logic                  take,
   output      sfre_pkg::req_slot_type slot
);

   logic                   valid_ff;
   logic                   valid_in;
   sfre_pkg::req_item_type item_ff;

   // Full register that is not consumed this cycle blocks the sender
   assign in_stall = valid_ff && !take;
   assign valid_in = in_valid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads on every accepted transfer
   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.item  = item_ff;

endmodule

`default_nettype wire

// File: rtl/core/sfre_core.sv
// Phase machine and counters of the erase sequencer; builds one command per step.
// Depends on sfre_pkg for opcodes and records.
`timescale 1ns / 1ps
`default_nettype none

module sfre_core #(
   parameter int SECTOR_COUNT  = sfre_pkg::SECTOR_COUNT_DEF,
   parameter int SECTOR_BYTES  = sfre_pkg::SECTOR_BYTES_DEF,
   parameter int BLOCK_SECTORS = sfre_pkg::BLOCK_SECTORS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire sfre_pkg::req_item_type item,
   output      sfre_pkg::step_out_type step
);

   localparam logic [sfre_pkg::SEC_W-1:0]  LastSec   = sfre_pkg::SEC_W'(SECTOR_COUNT - 1);
   localparam logic [sfre_pkg::SEC_W-1:0]  BlockSec  = sfre_pkg::SEC_W'(BLOCK_SECTORS);
   localparam logic [sfre_pkg::ADDR_W-1:0] SecBytesA = sfre_pkg::ADDR_W'(SECTOR_BYTES);

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_SAVE,
      PH_EWSR,
      PH_CLEAR,
      PH_WREN_PRE,
      PH_WREN_ONE,
      PH_ERASE_END,
      PH_POLL_END,
      PH_WREN_LOOP,
      PH_ERASE_LOOP,
      PH_POLL_LOOP,
      PH_WREN_RST,
      PH_EWSR_RST,
      PH_WRSR_RST
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [sfre_pkg::SEC_W-1:0]    cur_sec_ff, cur_sec_in;
   logic [sfre_pkg::SEC_W-1:0]    left_ff, left_in;
   logic [sfre_pkg::BYTE_W-1:0]   saved_ff, saved_in;

   logic [sfre_pkg::SEC_W-1:0]    lo_sec, hi_sec;
   logic                          range_bad;
   logic [sfre_pkg::ADDR_W-1:0]   sec_addr;
   logic                          blk_step;
   logic                          busy_rb;
   logic [sfre_pkg::SEC_W-1:0]    loop_cur_next, loop_left_next;

   // Range ordering and check on a start request
   assign lo_sec    = (item.first_sector < item.last_sector) ? item.first_sector
                                                             : item.last_sector;
   assign hi_sec    = (item.first_sector < item.last_sector) ? item.last_sector
                                                             : item.first_sector;
   assign range_bad = (item.first_sector > LastSec) || (item.last_sector > LastSec);

   // Byte address of the current sector, wrapping at the address width
   assign sec_addr = sfre_pkg::ADDR_W'(cur_sec_ff) * SecBytesA;

   // Erase loop advance: whole block while enough sectors remain, else one sector
   assign blk_step       = left_ff >= BlockSec;
   assign busy_rb        = item.returned_byte == sfre_pkg::STATUS_BUSY;
   assign loop_cur_next  = blk_step ? cur_sec_ff + BlockSec : cur_sec_ff + 1'b1;
   assign loop_left_next = blk_step ? left_ff - BlockSec
                                    : ((left_ff != '0) ? left_ff - 1'b1 : '0);

   // Next state and command for the request in the input register
   always_comb begin
      phase_in   = phase_ff;
      cur_sec_in = cur_sec_ff;
      left_in    = left_ff;
      saved_in   = saved_ff;
      step       = '0;

      if (item.action == sfre_pkg::ACT_START) begin
         if (phase_ff == PH_IDLE) begin
            step.has_rsp = 1'b1;
            if (range_bad) begin
               step.item.finished = 1'b1;
               step.item.failed   = 1'b1;
            end else begin
               cur_sec_in             = lo_sec;
               left_in                = hi_sec - lo_sec;
               phase_in               = PH_SAVE;
               step.item.opcode       = sfre_pkg::OP_RDSR;
               step.item.read_reply   = 1'b1;
            end
         end
      end else begin
         step.has_rsp = 1'b1;
         case (phase_ff)
            PH_SAVE: begin
               saved_in         = item.returned_byte;
               phase_in         = PH_EWSR;
               step.item.opcode = sfre_pkg::OP_EWSR;
            end
            PH_EWSR: begin
               phase_in            = PH_CLEAR;
               step.item.opcode    = sfre_pkg::OP_WRSR;
               step.item.send_data = 1'b1;
            end
            PH_CLEAR: begin
               phase_in         = PH_WREN_PRE;
               step.item.opcode = sfre_pkg::OP_WREN;
            end
            PH_WREN_PRE: begin
               if (left_ff == '0) begin
                  phase_in         = PH_WREN_ONE;
                  step.item.opcode = sfre_pkg::OP_WREN;
               end else if (left_ff == LastSec) begin
                  phase_in         = PH_ERASE_END;
                  step.item.opcode = sfre_pkg::OP_CE;
               end else begin
                  left_in          = left_ff + 1'b1;
                  phase_in         = PH_WREN_LOOP;
                  step.item.opcode = sfre_pkg::OP_WREN;
               end
            end
            PH_WREN_ONE: begin
               phase_in               = PH_ERASE_END;
               step.item.opcode       = sfre_pkg::OP_SE;
               step.item.send_address = 1'b1;
               step.item.address      = sec_addr;
            end
            PH_ERASE_END: begin
               phase_in             = PH_POLL_END;
               step.item.opcode     = sfre_pkg::OP_RDSR;
               step.item.read_reply = 1'b1;
            end
            PH_POLL_END: begin
               if (busy_rb) begin
                  step.item.opcode     = sfre_pkg::OP_RDSR;
                  step.item.read_reply = 1'b1;
               end else begin
                  phase_in           = PH_IDLE;
                  step.item.finished = 1'b1;
               end
            end
            PH_WREN_LOOP: begin
               phase_in               = PH_ERASE_LOOP;
               step.item.opcode       = blk_step ? sfre_pkg::OP_BE32 : sfre_pkg::OP_SE;
               step.item.send_address = 1'b1;
               step.item.address      = sec_addr;
            end
            PH_ERASE_LOOP: begin
               phase_in             = PH_POLL_LOOP;
               step.item.opcode     = sfre_pkg::OP_RDSR;
               step.item.read_reply = 1'b1;
            end
            PH_POLL_LOOP: begin
               if (busy_rb) begin
                  step.item.opcode     = sfre_pkg::OP_RDSR;
                  step.item.read_reply = 1'b1;
               end else begin
                  cur_sec_in       = loop_cur_next;
                  left_in          = loop_left_next;
                  phase_in         = (loop_left_next != '0) ? PH_WREN_LOOP : PH_WREN_RST;
                  step.item.opcode = sfre_pkg::OP_WREN;
               end
            end
            PH_WREN_RST: begin
               phase_in         = PH_EWSR_RST;
               step.item.opcode = sfre_pkg::OP_EWSR;
            end
            PH_EWSR_RST: begin
               phase_in            = PH_WRSR_RST;
               step.item.opcode    = sfre_pkg::OP_WRSR;
               step.item.send_data = 1'b1;
               step.item.data_byte = saved_ff;
            end
            PH_WRSR_RST: begin
               phase_in           = PH_IDLE;
               step.item.finished = 1'b1;
            end
            default: begin
               // completion with nothing outstanding
               phase_in     = PH_IDLE;
               step.has_rsp = 1'b0;
            end
         endcase
      end
   end

   // State advances only when a request is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         cur_sec_ff <= '0;
         left_ff    <= '0;
         saved_ff   <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         cur_sec_ff <= cur_sec_in;
         left_ff    <= left_in;
         saved_ff   <= saved_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/sfre_out_stage.sv
// Result register of the erase sequencer: holds one command transfer until taken.
// Depends on sfre_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module sfre_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire sfre_pkg::step_out_type step,
   output      logic                  out_free,
   output      logic                  out_valid,
   input  wire logic                  out_stall,
   output      sfre_pkg::rsp_item_type out_item
);

   logic                   valid_ff;
   logic                   valid_in;
   sfre_pkg::rsp_item_type item_ff;

   // Register can load when empty or being drained this cycle
   assign out_free = !valid_ff || !out_stall;
   assign valid_in = out_free ? (take && step.has_rsp) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && step.has_rsp) begin
         item_ff <= step.item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// File: rtl/core/sfre_checker.sv
// Port-level checks for the SPI flash range erase sequencer, bound to the top.
// Depends on sfre_pkg for opcodes and widths.
`timescale 1ns / 1ps
`default_nettype none

module sfre_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [sfre_pkg::BYTE_W-1:0] rsp_opcode,
   input wire logic                        rsp_send_address,
   input wire logic                        rsp_send_data,
   input wire logic                        rsp_read_reply,
   input wire logic                        rsp_finished,
   input wire logic                        rsp_failed
);

   // No result is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A stalled result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   // An end marker carries no command
   a_end_bare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_opcode == sfre_pkg::OP_NONE && !rsp_send_address
                                    && !rsp_send_data && !rsp_read_reply)
      else $error("end marker carries a command");

   // A rejected request is always an end marker
   a_fail_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_finished)
      else $error("failure without end marker");

   // Only status reads ask for a reply
   a_read_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_reply |-> rsp_opcode == sfre_pkg::OP_RDSR)
      else $error("reply requested for a non-status command");

endmodule

bind spi_flash_range_erase_sequencer_top sfre_checker u_sfre_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_opcode       (rsp_opcode),
   .rsp_send_address (rsp_send_address),
   .rsp_send_data    (rsp_send_data),
   .rsp_read_reply   (rsp_read_reply),
   .rsp_finished     (rsp_finished),
   .rsp_failed       (rsp_failed)
);

`default_nettype wire
